/* rtl/core/mfs_pkg.sv */
// ----------------------------------------------------------------------------
// mfs_pkg: shared types for the maximum frequency stack
// Word formats, status codes, controller states and the command and status
// groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mfs_pkg;

    localparam int MFS_CAPACITY    = 64;
    localparam int MFS_VALUE_WIDTH = 32;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_PUSHED = 2'd0,
        ST_POPPED = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } mfs_status_t;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] value;
    } mfs_in_t;

    typedef struct packed {
        mfs_status_t        status;
        logic signed [31:0] popped_value;
    } mfs_out_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_SCAN,
        CS_PUSH_WRITE,
        CS_SHIFT,
        CS_RESULT
    } mfs_state_t;

    typedef struct packed {
        logic        load;
        logic        scan;
        logic        shift;
        logic        shift_init;
        logic        push_commit;
        logic        pop_commit;
        logic        out_load;
        mfs_status_t out_status;
    } mfs_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic scan_done;
        logic out_free;
    } mfs_dp_status_t;

endpackage

`default_nettype wire

/* rtl/core/mfs_datapath.sv */
// ----------------------------------------------------------------------------
// mfs_datapath: entry memory, scan pipeline and output register
// Holds the entries in push order in a single-port-read memory, counts
// matches or tracks the highest level while scanning, closes the gap after a
// pop and keeps the result word until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module mfs_datapath #(
    parameter int CAPACITY    = mfs_pkg::MFS_CAPACITY,
    parameter int VALUE_WIDTH = mfs_pkg::MFS_VALUE_WIDTH
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  mfs_pkg::mfs_in_t       in_word,
    input  mfs_pkg::mfs_cmd_t      cmd,
    output mfs_pkg::mfs_dp_status_t status,
    input  wire                    out_ready,
    output logic                   out_valid,
    output mfs_pkg::mfs_out_t      out_word
);
    import mfs_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = VALUE_WIDTH + CW;

    logic [EW-1:0] mem [CAPACITY];
    logic [EW-1:0] rd_data_reg;

    logic [CW-1:0]          count_reg, count_next;
    logic                   op_mode_reg, op_mode_next;
    logic [VALUE_WIDTH-1:0] op_value_reg, op_value_next;
    logic [CW-1:0]          scan_idx_reg, scan_idx_next;
    logic                   proc_valid_reg, proc_valid_next;
    logic [AW-1:0]          proc_idx_reg, proc_idx_next;
    logic [CW-1:0]          match_reg, match_next;
    logic [CW-1:0]          best_reg, best_next;
    logic [AW-1:0]          pick_reg, pick_next;
    logic [VALUE_WIDTH-1:0] pick_value_reg, pick_value_next;
    logic                   out_valid_reg, out_valid_next;
    mfs_out_t               out_word_reg, out_word_next;

    logic                   issue;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [EW-1:0]          mem_wdata;
    logic [VALUE_WIDTH-1:0] rd_value;
    logic [CW-1:0]          rd_level;
    logic [63:0]            in_wide;
    logic [63:0]            pop_wide;

    assign rd_value = rd_data_reg[EW-1:CW];
    assign rd_level = rd_data_reg[CW-1:0];
    assign in_wide  = {32'b0, in_word.value};
    assign pop_wide = 64'(pick_value_reg);

    // full, empty, scan_done, out_free
    assign status = {(count_reg == CW'(CAPACITY)),
                     (count_reg == '0),
                     ((scan_idx_reg == count_reg) && !proc_valid_reg),
                     (!out_valid_reg || out_ready)};

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    always_comb
    begin
        count_next      = count_reg;
        op_mode_next    = op_mode_reg;
        op_value_next   = op_value_reg;
        scan_idx_next   = scan_idx_reg;
        proc_idx_next   = scan_idx_reg[AW-1:0];
        match_next      = match_reg;
        best_next       = best_reg;
        pick_next       = pick_reg;
        pick_value_next = pick_value_reg;
        out_valid_next  = out_valid_reg;
        out_word_next   = out_word_reg;

        issue = (cmd.scan || cmd.shift) && (scan_idx_reg < count_reg);
        proc_valid_next = issue;

        if (cmd.load)
        begin
            op_mode_next    = in_word.mode;
            op_value_next   = in_wide[VALUE_WIDTH-1:0];
            scan_idx_next   = '0;
            match_next      = '0;
            best_next       = '0;
            pick_next       = '0;
            proc_valid_next = 1'b0;
        end
        else if (cmd.shift_init)
        begin
            scan_idx_next = CW'(pick_reg) + CW'(1);
        end
        else if (issue)
        begin
            scan_idx_next = scan_idx_reg + CW'(1);
        end

        if (cmd.scan && proc_valid_reg)
        begin
            if (op_mode_reg == MODE_PUSH)
            begin
                if (rd_value == op_value_reg)
                begin
                    match_next = match_reg + CW'(1);
                end
            end
            else if (rd_level >= best_reg)
            begin
                // ties go to the later entry
                best_next       = rd_level;
                pick_next       = proc_idx_reg;
                pick_value_next = rd_value;
            end
        end

        mem_we    = cmd.push_commit || (cmd.shift && proc_valid_reg);
        mem_waddr = cmd.push_commit ? count_reg[AW-1:0] : proc_idx_reg - AW'(1);
        mem_wdata = cmd.push_commit ? {op_value_reg, match_reg + CW'(1)} : rd_data_reg;

        if (cmd.push_commit)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.pop_commit)
        begin
            count_next = count_reg - CW'(1);
        end

        if (cmd.out_load)
        begin
            out_valid_next       = 1'b1;
            out_word_next.status = cmd.out_status;
            out_word_next.popped_value = (cmd.out_status == ST_POPPED) ?
                                         signed'(pop_wide[31:0]) : 32'sd0;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[scan_idx_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            proc_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            proc_valid_reg <= proc_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_mode_reg    <= op_mode_next;
        op_value_reg   <= op_value_next;
        scan_idx_reg   <= scan_idx_next;
        proc_idx_reg   <= proc_idx_next;
        match_reg      <= match_next;
        best_reg       <= best_next;
        pick_reg       <= pick_next;
        pick_value_reg <= pick_value_next;
        out_word_reg   <= out_word_next;
    end

endmodule

`default_nettype wire

/* rtl/core/mfs_controller.sv */
// ----------------------------------------------------------------------------
// mfs_controller: operation sequencer
// Takes one word at a time, steps the datapath through scan, write or
// gap-closing shift, and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mfs_controller (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    output logic                    in_ready,
    input  wire                     in_mode,
    input  mfs_pkg::mfs_dp_status_t status,
    output mfs_pkg::mfs_cmd_t       cmd
);
    import mfs_pkg::*;

    mfs_state_t  state_reg, state_next;
    mfs_status_t res_status_reg, res_status_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= CS_IDLE;
            res_status_reg <= ST_PUSHED;
        end
        else
        begin
            state_reg      <= state_next;
            res_status_reg <= res_status_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        res_status_next = res_status_reg;
        case (state_reg)
            CS_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_mode == MODE_PUSH)
                    begin
                        res_status_next = status.full ? ST_FULL : ST_PUSHED;
                        state_next      = status.full ? CS_RESULT : CS_SCAN;
                    end
                    else
                    begin
                        res_status_next = status.empty ? ST_EMPTY : ST_POPPED;
                        state_next      = status.empty ? CS_RESULT : CS_SCAN;
                    end
                end
            end
            CS_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = (res_status_reg == ST_POPPED) ? CS_SHIFT : CS_PUSH_WRITE;
                end
            end
            CS_PUSH_WRITE:
            begin
                state_next = CS_RESULT;
            end
            CS_SHIFT:
            begin
                if (status.scan_done)
                begin
                    state_next = CS_RESULT;
                end
            end
            CS_RESULT:
            begin
                if (status.out_free)
                begin
                    state_next = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        cmd.out_status = res_status_reg;
        case (state_reg)
            CS_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            CS_SCAN:
            begin
                cmd.scan       = 1'b1;
                cmd.shift_init = status.scan_done && (res_status_reg == ST_POPPED);
            end
            CS_PUSH_WRITE:
            begin
                cmd.push_commit = 1'b1;
            end
            CS_SHIFT:
            begin
                cmd.shift      = 1'b1;
                cmd.pop_commit = status.scan_done;
            end
            CS_RESULT:
            begin
                cmd.out_load = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/max_frequency_stack.sv */
// ----------------------------------------------------------------------------
// max_frequency_stack: bounded maximum frequency stack
// A push stores a value with its level (one more than the live copies of
// that value); a pop removes the highest-level entry, newest first on a tie.
//
// Channels: in_word (mode, value) and out_word (status, popped_value), each
// with valid/ready. Every accepted word yields exactly one result word.
// One operation is in flight at a time; in_ready is high only while idle.
// With n live entries, a push scans all n and then writes the new entry;
// a pop scans all n and then shifts down each entry above the removed one.
// A full push or an empty pop goes straight to the result. The next word
// is taken in the cycle after the result is loaded. Both passes use the
// single read port of the entry memory, one entry per cycle, first to scan
// and then to close the gap left by a pop.
// A result waits in the output register while out_ready is low; the next
// word is still taken, and its result holds in the controller until that
// register frees up.
// Reset empties the store at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module max_frequency_stack #(
    parameter int CAPACITY    = mfs_pkg::MFS_CAPACITY,
    parameter int VALUE_WIDTH = mfs_pkg::MFS_VALUE_WIDTH
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    output logic              in_ready,
    input  mfs_pkg::mfs_in_t  in_word,
    output logic              out_valid,
    input  wire               out_ready,
    output mfs_pkg::mfs_out_t out_word
);
    import mfs_pkg::*;

    mfs_cmd_t       cmd;
    mfs_dp_status_t dp_status;

    mfs_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_mode  (in_word.mode),
        .status   (dp_status),
        .cmd      (cmd)
    );

    mfs_datapath #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_word),
        .cmd       (cmd),
        .status    (dp_status),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_word  (out_word)
    );

endmodule

`default_nettype wire

/* rtl/core/mfs_checker.sv */
// ----------------------------------------------------------------------------
// mfs_checker: port-level checks for the maximum frequency stack
// Watches the top-level handshakes and result words over time.
// ----------------------------------------------------------------------------
`default_nettype none

module mfs_checker (
    input wire               clk,
    input wire               rst_n,
    input wire               in_valid,
    input wire               in_ready,
    input mfs_pkg::mfs_in_t  in_word,
    input wire               out_valid,
    input wire               out_ready,
    input mfs_pkg::mfs_out_t out_word
);
    import mfs_pkg::*;

    // hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("result word changed while stalled");

    // only a pop carries a value
    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_word.status != ST_POPPED) |-> out_word.popped_value == 32'sd0)
        else $error("nonzero value on a result that is not a pop");

    // one word at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second word taken while busy");

    // a new result comes only out of a busy cycle
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without an operation in flight");

endmodule

bind max_frequency_stack mfs_checker u_mfs_checker (.*);

`default_nettype wire
